### rtl/slpl_pkg.sv
// Shared types and constants for the stereo look-ahead peak limiter.
// No dependencies; imported by every other file of the block.
package slpl_pkg;

   localparam int SAMPLE_W          = 24;   // Q4.20 sample
   localparam int CEIL_W            = 23;   // ceiling register
   localparam int LEN_REG_W         = 8;    // look-ahead length register
   localparam int GAIN_W            = 25;   // Q1.24 gain
   localparam int COEF_W            = 14;
   localparam int TDATA_W           = 48;   // two samples, already whole bytes
   localparam int CSR_IDX_W         = 1;
   localparam int DIV_STEPS         = 24;   // quotient bits of the gain divide
   localparam int DEF_MAX_LOOKAHEAD = 128;
   localparam int MIN_LOOKAHEAD     = 8;

   localparam logic [GAIN_W-1:0]    UNITY_GAIN  = 25'd16777216;
   localparam logic [COEF_W-1:0]    RISE_COEF   = 14'd10066;   // 0.0006 in Q0.24
   localparam logic [CEIL_W-1:0]    DEF_CEILING = 23'd1048576;
   localparam logic [LEN_REG_W-1:0] DEF_LEN     = 8'd96;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOKAHEAD = 1'b1;

   typedef struct packed {
      logic clear;       // zero the ring entry at the current position
      logic accept;      // take an item: ring read/write, peak, divider init
      logic div_step;    // one restoring divide step
      logic env_mul;     // wanted gain and rise step product
      logic env_upd;     // envelope update
      logic mul_en;      // sample magnitude times envelope
      logic mul_right;   // operand select for mul_en
      logic clamp_l;     // clamp left product into holding register
      logic out_load;    // load result register (right clamp, left, marker)
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;  // clear pass is at the last ring entry
   } dp_status_type;

endpackage

### rtl/slpl_ctrl.sv
// Sequencer for the limiter: clear pass, accept, divide, envelope, scale, output.
// Depends on slpl_pkg for command/status structs and the divide step count.
module slpl_ctrl import slpl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [7:0] {
      ST_CLEAR   = 8'b0000_0001,
      ST_IDLE    = 8'b0000_0010,
      ST_DIV     = 8'b0000_0100,
      ST_ENV_MUL = 8'b0000_1000,
      ST_ENV_UPD = 8'b0001_0000,
      ST_MUL_L   = 8'b0010_0000,
      ST_MUL_R   = 8'b0100_0000,
      ST_OUT     = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_ENV_MUL;
            end
         end
         ST_ENV_MUL: begin
            cmd.env_mul = 1'b1;
            state_in    = ST_ENV_UPD;
         end
         ST_ENV_UPD: begin
            cmd.env_upd = 1'b1;
            state_in    = ST_MUL_L;
         end
         ST_MUL_L: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_MUL_R;
         end
         ST_MUL_R: begin
            cmd.clamp_l   = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_right = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            // hold until the result register can take the new item
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/slpl_datapath.sv
// Limiter datapath: config registers, delay rings, gain divider, envelope, scaling.
// Depends on slpl_pkg; driven by slpl_ctrl through dp_cmd_type.
module slpl_datapath import slpl_pkg::*; #(
   parameter int MAX_LOOKAHEAD = DEF_MAX_LOOKAHEAD
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CEIL_W-1:0]          csr_wdata,
   input  logic signed [SAMPLE_W-1:0] left_in,
   input  logic signed [SAMPLE_W-1:0] right_in,
   input  logic                       block_last,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   output logic signed [SAMPLE_W-1:0] left_out,
   output logic signed [SAMPLE_W-1:0] right_out,
   output logic                       block_last_out
);

   localparam int POS_W  = $clog2(MAX_LOOKAHEAD);
   localparam int LEN_W  = ($clog2(MAX_LOOKAHEAD + 1) > LEN_REG_W) ?
                           $clog2(MAX_LOOKAHEAD + 1) : LEN_REG_W;
   localparam int EPROD_W = GAIN_W + COEF_W;
   localparam int PROD_W  = SAMPLE_W + GAIN_W;

   function automatic logic [SAMPLE_W-1:0] mag(input logic signed [SAMPLE_W-1:0] v);
      return v[SAMPLE_W-1] ? -v : v;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] clamp(input logic [PROD_W-1:0] p,
                                                        input logic neg,
                                                        input logic [CEIL_W-1:0] c);
      logic [GAIN_W-1:0] m;
      m = p[PROD_W-1:24];
      if (m > GAIN_W'(c)) begin
         m = GAIN_W'(c);
      end
      return neg ? -m[SAMPLE_W-1:0] : m[SAMPLE_W-1:0];
   endfunction

   // config
   logic [CEIL_W-1:0]    ceil_ff;
   logic [LEN_REG_W-1:0] len_ff;

   // ring
   logic signed [SAMPLE_W-1:0] mem_l [MAX_LOOKAHEAD];
   logic signed [SAMPLE_W-1:0] mem_r [MAX_LOOKAHEAD];
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [LEN_W-1:0]           len_ext, len_eff, pos_inc;
   logic signed [SAMPLE_W-1:0] dl_ff, dr_ff;
   logic                       last_ff;

   // divider
   logic [SAMPLE_W-1:0] mag_l, mag_r, peak_in, peak_ff;
   logic                big_ff;
   logic [SAMPLE_W-1:0] rem_ff, rem_in, quo_ff;
   logic [SAMPLE_W:0]   rem_sh;
   logic                fits;

   // envelope
   logic [GAIN_W-1:0]  want_sel, want_ff, env_ff, env_in, diff;
   logic               down_ff;
   logic [EPROD_W-1:0] eprod_ff;

   // scaling
   logic [SAMPLE_W-1:0]        mul_op;
   logic [PROD_W-1:0]          prod_ff;
   logic signed [SAMPLE_W-1:0] resl_ff, rsp_l_ff, rsp_r_ff;
   logic                       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ceil_ff <= DEF_CEILING;
         len_ff  <= DEF_LEN;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CEILING:   ceil_ff <= csr_wdata;
            CSR_LOOKAHEAD: len_ff  <= csr_wdata[LEN_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // effective length and next position
   always_comb begin
      len_ext = LEN_W'(len_ff);
      if (len_ext < LEN_W'(MIN_LOOKAHEAD)) begin
         len_eff = LEN_W'(MIN_LOOKAHEAD);
      end else if (len_ext > LEN_W'(MAX_LOOKAHEAD)) begin
         len_eff = LEN_W'(MAX_LOOKAHEAD);
      end else begin
         len_eff = len_ext;
      end
      pos_inc = LEN_W'(pos_ff) + LEN_W'(1);
      pos_in  = (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];
   end

   assign status.clear_done = (pos_ff == POS_W'(MAX_LOOKAHEAD - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (cmd.clear) begin
         pos_ff <= status.clear_done ? '0 : pos_ff + POS_W'(1);
      end else if (cmd.accept) begin
         pos_ff <= pos_in;
      end
   end

   // ring memories: old entry read out, new sample written in the same edge
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem_l[pos_ff] <= '0;
         mem_r[pos_ff] <= '0;
      end else if (cmd.accept) begin
         dl_ff         <= mem_l[pos_ff];
         dr_ff         <= mem_r[pos_ff];
         mem_l[pos_ff] <= left_in;
         mem_r[pos_ff] <= right_in;
      end
   end

   // wanted gain = (ceiling << 24) / peak, restoring, one bit per step
   assign mag_l   = mag(left_in);
   assign mag_r   = mag(right_in);
   assign peak_in = (mag_r > mag_l) ? mag_r : mag_l;
   assign rem_sh  = {rem_ff, 1'b0};
   assign fits    = rem_sh >= {1'b0, peak_ff};
   assign rem_in  = fits ? SAMPLE_W'(rem_sh - {1'b0, peak_ff}) : rem_sh[SAMPLE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         last_ff <= block_last;
         peak_ff <= peak_in;
         big_ff  <= peak_in > SAMPLE_W'(ceil_ff);
         rem_ff  <= SAMPLE_W'(ceil_ff);
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[SAMPLE_W-2:0], fits};
      end
   end

   // envelope: instant attack, truncated slow release
   assign want_sel = big_ff ? {1'b0, quo_ff} : UNITY_GAIN;
   assign diff     = want_sel - env_ff;
   assign env_in   = down_ff ? want_ff
                             : env_ff + GAIN_W'(eprod_ff[EPROD_W-1:24]);

   always_ff @(posedge clock) begin
      if (cmd.env_mul) begin
         want_ff  <= want_sel;
         down_ff  <= want_sel < env_ff;
         eprod_ff <= EPROD_W'(diff) * EPROD_W'(RISE_COEF);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= UNITY_GAIN;
      end else if (cmd.env_upd) begin
         env_ff <= env_in;
      end
   end

   // shared multiplier, left then right
   assign mul_op = cmd.mul_right ? mag(dr_ff) : mag(dl_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= PROD_W'(mul_op) * PROD_W'(env_ff);
      end
      if (cmd.clamp_l) begin
         resl_ff <= clamp(prod_ff, dl_ff[SAMPLE_W-1], ceil_ff);
      end
      if (cmd.out_load) begin
         rsp_l_ff    <= resl_ff;
         rsp_r_ff    <= clamp(prod_ff, dr_ff[SAMPLE_W-1], ceil_ff);
         rsp_last_ff <= last_ff;
      end
   end

   assign left_out       = rsp_l_ff;
   assign right_out      = rsp_r_ff;
   assign block_last_out = rsp_last_ff;

endmodule

### rtl/stereo_lookahead_peak_limiter_top.sv
// Top level of the stereo look-ahead peak limiter.
// Depends on slpl_pkg, slpl_ctrl and slpl_datapath.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-----------------------------------------------
//  req     | in  | req_tvalid / req_tready | tdata: left_in, right_in; tuser: block_last
//  rsp     | out | rsp_tvalid / rsp_tready | tdata: left_out, right_out; tuser: block_last_out
//  csr     | in  | csr_we (no wait)        | csr_index, csr_wdata
//
// One item at a time: after the accepting edge come the divide, envelope and
// scaling steps, and the result is loaded once the result register is free; the
// next item can be accepted the cycle after the result is loaded. The pace comes
// from the 24-step restoring divider that forms the wanted gain, plus envelope and
// a single shared scaling multiplier. After reset a clear pass zeroes the look-ahead
// rings, one entry per cycle, with req_tready low; csr writes are taken meanwhile.
// The result register lets a new item be accepted while the previous result
// waits; a second finished result holds inside until rsp_tready frees the slot.
module stereo_lookahead_peak_limiter_top import slpl_pkg::*; #(
   parameter int MAX_LOOKAHEAD = DEF_MAX_LOOKAHEAD
) (
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,   // [23:0] left_in, [47:24] right_in
   input  logic                 req_tuser,   // [0] block_last
   // result items
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,   // [23:0] left_out, [47:24] right_out
   output logic                 rsp_tuser,   // [0] block_last_out
   // configuration writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,   // 0 ceiling_level, 1 lookahead_len
   input  logic [CEIL_W-1:0]    csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   logic signed [SAMPLE_W-1:0] left_in, right_in, left_out, right_out;
   logic                       block_last_out;

   assign left_in  = req_tdata[SAMPLE_W-1:0];
   assign right_in = req_tdata[2*SAMPLE_W-1:SAMPLE_W];

   assign rsp_tdata = {right_out, left_out};
   assign rsp_tuser = block_last_out;

   slpl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   slpl_datapath #(
      .MAX_LOOKAHEAD (MAX_LOOKAHEAD)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .left_in        (left_in),
      .right_in       (right_in),
      .block_last     (req_tuser),
      .cmd            (cmd),
      .status         (status),
      .left_out       (left_out),
      .right_out      (right_out),
      .block_last_out (block_last_out)
   );

endmodule

### rtl/slpl_checker.sv
// Port-level checks for the limiter top, attached by the bind at the end.
// Depends on slpl_pkg and stereo_lookahead_peak_limiter_top.
module slpl_checker import slpl_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [TDATA_W-1:0] rsp_tdata,
   input logic               rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one item in flight: no second accept right after one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   // a result never appears the cycle after an accept
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result too soon after accept");

   // reset empties the result register and blocks input for the clear pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("active after reset");

endmodule

bind stereo_lookahead_peak_limiter_top slpl_checker u_slpl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
